@@ design/smc_pkg.sv @@
// package for the stack machine core
// types, opcodes and sequencer states shared by the core and the alu
package smc_pkg;
    localparam int MemWordsDefault = 65536;
    localparam int WordW = 16;

    typedef enum logic [1:0] {
        OPER_WRITE = 2'd0,
        OPER_READ  = 2'd1,
        OPER_STEP  = 2'd2,
        OPER_NONE  = 2'd3
    } oper_t;

    typedef enum logic [4:0] {
        OP_HALT = 5'd0, OP_NOP = 5'd1, OP_ADD = 5'd2, OP_SUB = 5'd3,
        OP_MULT = 5'd4, OP_DIV = 5'd5, OP_CALL = 5'd6, OP_RET = 5'd7,
        OP_JMP = 5'd8, OP_JEQ = 5'd9, OP_PRINTI = 5'd10, OP_PRINTS = 5'd11,
        OP_PUSHC = 5'd12, OP_PUSHA = 5'd13, OP_PUSHR = 5'd14,
        OP_POPA = 5'd15, OP_POPR = 5'd16
    } opcode_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0, ALU_SUB = 2'd1, ALU_MUL = 2'd2, ALU_DIV = 2'd3
    } alu_op_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_FETCH, ST_DEC, ST_OPND, ST_OPND2,
        ST_V1, ST_V2, ST_ALU, ST_ALU_WAIT, ST_WB, ST_CALL1, ST_CALL2,
        ST_RET1, ST_RET2, ST_RET3, ST_RET4, ST_PUSHX, ST_POP1, ST_POP2,
        ST_TOS, ST_TOS2, ST_OUT
    } state_t;
endpackage

@@ design/stack_machine_cpu_core.sv @@
// stack machine core top level: sequencer, registers, memory and alu
// depends on smc_pkg, smc_ram, smc_alu
// throughput: one transaction at a time, next accepted as soon as the result is registered
// reset: a clearing pass zeroes every memory word, input not ready meanwhile
// reset also sets pc 0, sp MEMORY_WORDS, fp 0, flags clear
module stack_machine_cpu_core #(
    parameter int MEMORY_WORDS = smc_pkg::MemWordsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation[1:0], mem_address[17:2], mem_data[33:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // read_data, print_valid, print_value, halted, fault,
                                   // top_of_stack from bit 0 up
);
    import smc_pkg::*;

    localparam int AW = $clog2(MEMORY_WORDS);

    state_t      state_reg, state_next;
    logic [15:0] pc_reg, pc_next;
    logic [16:0] sp_reg, sp_next;
    logic [15:0] fp_reg, fp_next;
    logic        halt_reg, halt_next, fault_reg, fault_next;
    logic [AW:0] clr_reg, clr_next;
    opcode_t     opc_reg, opc_next;
    logic [15:0] w_reg, w_next, v1_reg, v1_next, v2_reg, v2_next;
    logic [15:0] rdd_reg, rdd_next, pv_reg, pv_next;
    logic        pval_reg, pval_next;
    logic [15:0] tos_reg, tos_next;
    logic        mv_reg, mv_next;
    logic [55:0] out_reg, out_next;

    logic          mem_we;
    logic [15:0]   mem_a, mem_wd, mem_rd;
    logic          alu_start, alu_done;
    alu_op_t       alu_op;
    logic [15:0]   alu_res;

    smc_ram #(.Width(16), .Depth(MEMORY_WORDS)) u_ram (
        .aclk(aclk), .we(mem_we), .addr(mem_a[AW-1:0]), .wdata(mem_wd), .rdata(mem_rd)
    );

    smc_alu u_alu (
        .aclk(aclk), .aresetn(aresetn), .start(alu_start), .op(alu_op),
        .a(v2_reg), .b(v1_reg), .done(alu_done), .result(alu_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            pc_reg    <= '0;
            sp_reg    <= 17'(MEMORY_WORDS);
            fp_reg    <= '0;
            halt_reg  <= 1'b0;
            fault_reg <= 1'b0;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            fp_reg    <= fp_next;
            halt_reg  <= halt_next;
            fault_reg <= fault_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
        opc_reg  <= opc_next;
        w_reg    <= w_next;
        v1_reg   <= v1_next;
        v2_reg   <= v2_next;
        rdd_reg  <= rdd_next;
        pv_reg   <= pv_next;
        pval_reg <= pval_next;
        tos_reg  <= tos_next;
        out_reg  <= out_next;
    end

    always_comb begin
        state_next = state_reg;
        pc_next = pc_reg; sp_next = sp_reg; fp_next = fp_reg;
        halt_next = halt_reg; fault_next = fault_reg;
        clr_next = clr_reg; opc_next = opc_reg;
        w_next = w_reg; v1_next = v1_reg; v2_next = v2_reg;
        rdd_next = rdd_reg; pv_next = pv_reg; pval_next = pval_reg;
        tos_next = tos_reg; mv_next = mv_reg; out_next = out_reg;
        mem_we = 1'b0; mem_a = '0; mem_wd = '0;
        alu_start = 1'b0; alu_op = ALU_ADD;
        s_tready = 1'b0;
        if (mv_reg && m_tready) mv_next = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_a  = 16'(clr_reg[AW-1:0]);
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(MEMORY_WORDS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    rdd_next = '0; pval_next = 1'b0; pv_next = '0;
                    case (oper_t'(s_tdata[1:0]))
                        OPER_WRITE: begin
                            mem_we = 1'b1; mem_a = s_tdata[17:2]; mem_wd = s_tdata[33:18];
                            state_next = ST_TOS;
                        end
                        OPER_READ: begin
                            mem_a = s_tdata[17:2];
                            state_next = ST_RD;
                        end
                        OPER_STEP: state_next = halt_reg ? ST_TOS : ST_FETCH;
                        default:   state_next = ST_TOS;
                    endcase
                end
            end
            ST_RD: begin
                rdd_next = mem_rd;
                state_next = ST_TOS;
            end
            ST_FETCH: begin
                mem_a = pc_reg;
                pc_next = pc_reg + 16'd1;
                state_next = ST_DEC;
            end
            ST_DEC: begin
                opc_next = (mem_rd > 16'd16) ? OP_NOP : opcode_t'(mem_rd[4:0]);
                case ((mem_rd > 16'd16) ? OP_NOP : opcode_t'(mem_rd[4:0]))
                    OP_HALT: begin halt_next = 1'b1; state_next = ST_TOS; end
                    OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_JEQ, OP_PRINTI: begin
                        mem_a = sp_reg[15:0]; state_next = ST_V1;
                    end
                    OP_CALL, OP_RET, OP_JMP, OP_PUSHC, OP_PUSHA, OP_PUSHR,
                    OP_POPA, OP_POPR: begin
                        mem_a = pc_reg; state_next = ST_OPND;
                    end
                    OP_PRINTS: begin pc_next = pc_reg + 16'd1; state_next = ST_TOS; end
                    default: state_next = ST_TOS;
                endcase
            end
            ST_V1: begin
                v1_next = mem_rd;
                case (opc_reg)
                    OP_JEQ: begin
                        sp_next = sp_reg + 17'd1;
                        if (mem_rd == 16'd0) begin
                            mem_a = pc_reg; state_next = ST_OPND;
                        end else begin
                            pc_next = pc_reg + 16'd1; state_next = ST_TOS;
                        end
                    end
                    OP_PRINTI: begin
                        sp_next = sp_reg + 17'd1;
                        pval_next = 1'b1; pv_next = mem_rd;
                        state_next = ST_TOS;
                    end
                    default: begin
                        mem_a = 16'(sp_reg + 17'd1); state_next = ST_V2;
                    end
                endcase
            end
            ST_V2: begin
                v2_next = mem_rd;
                if (opc_reg == OP_DIV && v1_reg == 16'd0) begin
                    halt_next = 1'b1; fault_next = 1'b1; state_next = ST_TOS;
                end else begin
                    state_next = ST_ALU;
                end
            end
            ST_ALU: begin
                alu_start = 1'b1;
                case (opc_reg)
                    OP_ADD:  alu_op = ALU_ADD;
                    OP_SUB:  alu_op = ALU_SUB;
                    OP_MULT: alu_op = ALU_MUL;
                    default: alu_op = ALU_DIV;
                endcase
                sp_next = sp_reg + 17'd1;
                state_next = ST_ALU_WAIT;
            end
            ST_ALU_WAIT: begin
                if (alu_done) begin
                    mem_we = 1'b1; mem_a = sp_reg[15:0]; mem_wd = alu_res;
                    state_next = ST_TOS;
                end
            end
            ST_OPND: begin
                w_next = mem_rd;
                case (opc_reg)
                    OP_JMP, OP_JEQ: begin pc_next = mem_rd; state_next = ST_TOS; end
                    OP_CALL: begin
                        sp_next = sp_reg - 17'd1;
                        mem_we = 1'b1; mem_a = 16'(sp_reg - 17'd1);
                        mem_wd = pc_reg + 16'd1;
                        state_next = ST_CALL1;
                    end
                    OP_RET: begin
                        mem_a = fp_reg + 16'd1; state_next = ST_RET1;
                    end
                    OP_PUSHC: begin
                        pc_next = pc_reg + 16'd1; state_next = ST_PUSHX;
                    end
                    OP_PUSHA: begin
                        mem_a = mem_rd; pc_next = pc_reg + 16'd1; state_next = ST_OPND2;
                    end
                    OP_PUSHR: begin
                        mem_a = fp_reg + mem_rd; pc_next = pc_reg + 16'd1;
                        state_next = ST_OPND2;
                    end
                    default: begin
                        if (opc_reg == OP_POPR) w_next = fp_reg + mem_rd;
                        mem_a = sp_reg[15:0]; pc_next = pc_reg + 16'd1;
                        state_next = ST_POP1;
                    end
                endcase
            end
            ST_OPND2: begin
                w_next = mem_rd; state_next = ST_PUSHX;
            end
            ST_PUSHX: begin
                sp_next = sp_reg - 17'd1;
                mem_we = 1'b1; mem_a = 16'(sp_reg - 17'd1); mem_wd = w_reg;
                state_next = ST_TOS;
            end
            ST_POP1: begin
                sp_next = sp_reg + 17'd1;
                mem_we = 1'b1; mem_a = w_reg; mem_wd = mem_rd;
                state_next = ST_TOS;
            end
            ST_CALL1: begin
                sp_next = sp_reg - 17'd1;
                mem_we = 1'b1; mem_a = 16'(sp_reg - 17'd1); mem_wd = fp_reg;
                state_next = ST_CALL2;
            end
            ST_CALL2: begin
                fp_next = sp_reg[15:0]; pc_next = w_reg; state_next = ST_TOS;
            end
            ST_RET1: begin
                pc_next = mem_rd; mem_a = sp_reg[15:0]; state_next = ST_RET2;
            end
            ST_RET2: begin
                sp_next = 17'({1'b0, fp_reg} + {{1{w_reg[15]}}, w_reg});
                mem_we = 1'b1; mem_a = fp_reg + w_reg; mem_wd = mem_rd;
                state_next = ST_RET3;
            end
            ST_RET3: begin
                mem_a = fp_reg; state_next = ST_RET4;
            end
            ST_RET4: begin
                fp_next = mem_rd; state_next = ST_TOS;
            end
            ST_TOS: begin
                mem_a = sp_reg[15:0]; state_next = ST_TOS2;
            end
            ST_TOS2: begin
                tos_next = mem_rd; state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait here while the previous result is still held
                if (!mv_reg || m_tready) begin
                    out_next = {5'b00000, tos_reg, fault_reg, halt_reg, pv_reg, pval_reg,
                                rdd_reg};
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) fault_reg |-> halt_reg)
        else $error("fault without halt");
    assert property (@(posedge aclk) disable iff (!aresetn) !(mem_we && alu_start))
        else $error("write during alu start");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
endmodule

@@ design/smc_ram.sv @@
// generic single port ram with registered read
// no dependencies
module smc_ram #(
    parameter int Width = 16,
    parameter int Depth = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ design/smc_alu.sv @@
// shared multi-cycle arithmetic unit: add, sub, multiply, restoring divide
// depends on smc_pkg
module smc_alu (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  smc_pkg::alu_op_t       op,
    input  logic [15:0]            a,
    input  logic [15:0]            b,
    output logic                   done,
    output logic [15:0]            result
);
    import smc_pkg::*;

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] div_reg, div_next;
    logic        neg_reg, neg_next;
    logic [15:0] res_reg, res_next;
    logic        done_reg, done_next;
    logic [15:0] abs_a, abs_b;
    logic [16:0] trial;
    logic [31:0] prod;

    assign abs_a = a[15] ? 16'(-a) : a;
    assign abs_b = b[15] ? 16'(-b) : b;
    assign trial = {rem_reg[15:0], quo_reg[15]};
    assign prod  = a * b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        if (start) begin
            case (op)
                ALU_ADD: begin
                    res_next  = a + b;
                    done_next = 1'b1;
                end
                ALU_SUB: begin
                    res_next  = a - b;
                    done_next = 1'b1;
                end
                ALU_MUL: begin
                    res_next  = prod[15:0];
                    done_next = 1'b1;
                end
                default: begin
                    // a dividend, b divisor
                    busy_next = 1'b1;
                    cnt_next  = 5'd16;
                    quo_next  = abs_a;
                    rem_next  = '0;
                    div_next  = abs_b;
                    neg_next  = a[15] ^ b[15];
                end
            endcase
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[14:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? 16'(-quo_next) : quo_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule
